// ===== hw/rtl/npc_pkg.sv =====
// Shared types, constants and helpers for the nearest palette color search unit.
`default_nettype none

package npc_pkg;

   // Field widths
   localparam int CHANNEL_W = 8;
   localparam int ENTRY_W   = 3 * CHANNEL_W;
   localparam int INDEX_W   = 8;
   localparam int DIFF_W    = CHANNEL_W + 2;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int DIST_W    = SQ_W + 2;

   // Palette geometry
   localparam int NPC_PALETTE_ENTRIES = 256;
   localparam int INDEX_LIMIT         = 256;
   localparam int CHANNEL_SHIFT       = 2;

   // Beat kinds carried on tuser
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } npc_state_type;

   // Per-cycle scan control handed to the distance unit
   typedef struct packed {
      logic valid;
      logic last;
   } npc_scan_ctl_type;

   // Magnitude of query minus stored channel scaled by four
   function automatic logic [DIFF_W-1:0] abs_diff(input logic [CHANNEL_W-1:0] query,
                                                  input logic [CHANNEL_W-1:0] stored);
      logic [DIFF_W-1:0] scaled;
      logic [DIFF_W-1:0] q_ext;
      scaled = {stored, 2'b00};
      q_ext  = DIFF_W'(query);
      if (q_ext > scaled) begin
         abs_diff = q_ext - scaled;
      end else begin
         abs_diff = scaled - q_ext;
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/npc_cell.sv =====
// One palette cell of the rotating ring: holds one entry and passes it on while scanning.
`default_nettype none

module npc_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          shift_en,
   input  wire logic                          load_en,
   input  wire logic [npc_pkg::ENTRY_W-1:0]   load_data,
   input  wire logic [npc_pkg::ENTRY_W-1:0]   next_data,
   output logic      [npc_pkg::ENTRY_W-1:0]   data_out
);

   logic [npc_pkg::ENTRY_W-1:0] data_ff;
   logic [npc_pkg::ENTRY_W-1:0] data_in;

   // Take the neighbor's entry while scanning, else load or hold
   always_comb begin
      data_in = data_ff;
      if (shift_en) begin
         data_in = next_data;
      end else if (load_en) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/npc_dist.sv =====
// Three-stage squared distance pipeline with running minimum over the scanned entries.
`default_nettype none

module npc_dist #(
   parameter int IDX_W = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire npc_pkg::npc_scan_ctl_type           scan_ctl,
   input  wire logic [IDX_W-1:0]                    scan_idx,
   input  wire logic [npc_pkg::ENTRY_W-1:0]         entry,
   input  wire logic [npc_pkg::CHANNEL_W-1:0]       query_red,
   input  wire logic [npc_pkg::CHANNEL_W-1:0]       query_green,
   input  wire logic [npc_pkg::CHANNEL_W-1:0]       query_blue,
   output logic      [IDX_W-1:0]                    win_idx,
   output logic                                     done
);

   localparam int CW = npc_pkg::CHANNEL_W;

   // Stage A: channel differences
   npc_pkg::npc_scan_ctl_type   a_ctl_ff;
   logic [IDX_W-1:0]            a_idx_ff;
   logic [npc_pkg::DIFF_W-1:0]  a_dr_ff, a_dg_ff, a_db_ff;

   // Stage B: channel squares
   npc_pkg::npc_scan_ctl_type   b_ctl_ff;
   logic [IDX_W-1:0]            b_idx_ff;
   logic [npc_pkg::SQ_W-1:0]    b_sr_ff, b_sg_ff, b_sb_ff;

   // Stage C: running minimum
   logic [npc_pkg::DIST_W-1:0]  min_dist_ff;
   logic [IDX_W-1:0]            win_idx_ff;
   logic                        done_ff;

   logic [npc_pkg::DIST_W-1:0]  sum_in;
   logic                        take_in;

   // Control valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         a_ctl_ff <= scan_ctl;
         b_ctl_ff <= a_ctl_ff;
         done_ff  <= b_ctl_ff.valid & b_ctl_ff.last;
      end
   end

   // Differences against the entry at the ring head
   always_ff @(posedge clock) begin
      a_idx_ff <= scan_idx;
      a_dr_ff  <= npc_pkg::abs_diff(query_red,   entry[3*CW-1:2*CW]);
      a_dg_ff  <= npc_pkg::abs_diff(query_green, entry[2*CW-1:CW]);
      a_db_ff  <= npc_pkg::abs_diff(query_blue,  entry[CW-1:0]);
   end

   // Square each channel difference
   always_ff @(posedge clock) begin
      b_idx_ff <= a_idx_ff;
      b_sr_ff  <= npc_pkg::SQ_W'(a_dr_ff) * npc_pkg::SQ_W'(a_dr_ff);
      b_sg_ff  <= npc_pkg::SQ_W'(a_dg_ff) * npc_pkg::SQ_W'(a_dg_ff);
      b_sb_ff  <= npc_pkg::SQ_W'(a_db_ff) * npc_pkg::SQ_W'(a_db_ff);
   end

   // Sum and compare; strict less keeps the lower index on a tie
   always_comb begin
      sum_in  = npc_pkg::DIST_W'(b_sr_ff) + npc_pkg::DIST_W'(b_sg_ff)
              + npc_pkg::DIST_W'(b_sb_ff);
      take_in = b_ctl_ff.valid & ((b_idx_ff == '0) | (sum_in < min_dist_ff));
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         min_dist_ff <= sum_in;
         win_idx_ff  <= b_idx_ff;
      end
   end

   assign win_idx = win_idx_ff;
   assign done    = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_palette_color_search_unit.sv =====
// A query beat starts a scan of every entry; its response is registered after the drain.
// No new beat is taken until a query is done; the ring of palette cells rotates
//   one entry per cycle past the shared distance pipeline; loads do not start a scan.
// Loads are accepted again as soon as the previous beat is handled, even with a response pending.
// Reset (synchronous, active high) clears every palette entry to zero and idles the sequencer.
`default_nettype none

module nearest_palette_color_search_unit #(
   parameter int PALETTE_ENTRIES = npc_pkg::NPC_PALETTE_ENTRIES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
   input  wire logic [0:0]  req_tuser,   // kind[0]
   // Response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // closest_index[7:0]
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam int CW    = npc_pkg::CHANNEL_W;

   // Request fields
   logic                    req_kind;
   logic [npc_pkg::INDEX_W-1:0] req_entry_index;
   logic [CW-1:0]           req_red, req_green, req_blue;

   assign req_kind        = req_tuser[0];
   assign req_entry_index = req_tdata[7:0];
   assign req_red         = req_tdata[15:8];
   assign req_green       = req_tdata[23:16];
   assign req_blue        = req_tdata[31:24];

   // Sequencer and payload registers
   npc_pkg::npc_state_type  state_ff, state_in;
   logic [IDX_W-1:0]        scan_cnt_ff, scan_cnt_in;
   logic [CW-1:0]           query_red_ff, query_green_ff, query_blue_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_data_ff, rsp_data_in;

   logic                    req_beat;
   logic                    load_beat;
   logic                    query_beat;
   logic                    shift_en;
   logic                    scan_last;
   npc_pkg::npc_scan_ctl_type scan_ctl;

   logic [npc_pkg::ENTRY_W-1:0] cell_data [PALETTE_ENTRIES];
   logic [IDX_W-1:0]        win_idx;
   logic                    dist_done;

   assign req_beat   = req_tvalid & req_tready;
   assign load_beat  = req_beat & (req_kind == npc_pkg::KIND_LOAD);
   assign query_beat = req_beat & (req_kind == npc_pkg::KIND_QUERY);
   assign scan_last  = (scan_cnt_ff == IDX_W'(PALETTE_ENTRIES - 1));

   // Ring of palette cells; cell zero is the head seen by the distance unit
   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      localparam int  NEXT     = (i + 1) % PALETTE_ENTRIES;
      localparam bit  WRITABLE = (i < npc_pkg::INDEX_LIMIT);
      logic load_hit;

      assign load_hit = WRITABLE & load_beat & (req_entry_index == 8'(i));

      npc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .load_en   (load_hit),
         .load_data ({req_red, req_green, req_blue}),
         .next_data (cell_data[NEXT]),
         .data_out  (cell_data[i])
      );
   end

   npc_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .scan_ctl    (scan_ctl),
      .scan_idx    (scan_cnt_ff),
      .entry       (cell_data[0]),
      .query_red   (query_red_ff),
      .query_green (query_green_ff),
      .query_blue  (query_blue_ff),
      .win_idx     (win_idx),
      .done        (dist_done)
   );

   // Next state, scan control and response register
   always_comb begin
      state_in       = state_ff;
      scan_cnt_in    = scan_cnt_ff;
      req_tready     = 1'b0;
      shift_en       = 1'b0;
      scan_ctl       = '0;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_data_in    = rsp_data_ff;
      case (state_ff)
         npc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (query_beat) begin
               state_in = npc_pkg::ST_SCAN;
            end
         end
         npc_pkg::ST_SCAN: begin
            shift_en       = 1'b1;
            scan_ctl.valid = 1'b1;
            scan_ctl.last  = scan_last;
            if (scan_last) begin
               scan_cnt_in = '0;
               state_in    = npc_pkg::ST_DRAIN;
            end else begin
               scan_cnt_in = scan_cnt_ff + IDX_W'(1);
            end
         end
         npc_pkg::ST_DRAIN: begin
            if (dist_done) begin
               state_in = npc_pkg::ST_DONE;
            end
         end
         npc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 8'(win_idx);
               state_in     = npc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npc_pkg::ST_IDLE;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the query color and response payload
   always_ff @(posedge clock) begin
      if (query_beat) begin
         query_red_ff   <= req_red;
         query_green_ff <= req_green;
         query_blue_ff  <= req_blue;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Scan counter rests at zero so the ring is home whenever a beat can be taken
   a_cnt_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff != npc_pkg::ST_SCAN) |-> (scan_cnt_ff == '0))
      else $error("scan counter not at zero outside a scan");

   // Distance unit finishes only while the sequencer waits for it
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      dist_done |-> (state_ff == npc_pkg::ST_DRAIN))
      else $error("distance result outside drain");

   // Last scan step moves to drain
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == npc_pkg::ST_SCAN) && scan_last) |=> (state_ff == npc_pkg::ST_DRAIN))
      else $error("scan did not end after the last entry");

   // A response is only raised from the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == npc_pkg::ST_DONE))
      else $error("response raised outside done state");

endmodule

`default_nettype wire

// ===== test/nearest_palette_color_search_unit_test.sv =====
// Self-checking testbench for the nearest palette color search unit.
module nearest_palette_color_search_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOTAL_BEATS   = 850;
   localparam int MID_PAUSE_AT  = 420;
   localparam int IDLE_PERCENT  = 32;
   localparam int TAIL_CYCLES   = npc_pkg::NPC_PALETTE_ENTRIES + 40;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef struct {
      logic       kind;
      logic [7:0] entry_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit         wait_for_empty;
   } palette_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
   logic [0:0]  req_tuser  = '0;   // kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // closest_index[7:0]

   palette_beat_type beat_queue[$];
   logic [7:0]    closest_expected[$];
   logic [23:0]   palette_shadow[npc_pkg::NPC_PALETTE_ENTRIES];

   int  beats_planned    = 0;
   int  beats_accepted   = 0;
   int  loads_accepted   = 0;
   int  queries_accepted = 0;
   int  responses_seen   = 0;
   int  mismatch_count   = 0;
   int  cycle_count      = 0;
   bit  hold_for_drain   = 1'b0;

   // No random idling on either side while this window of beats goes through
   wire steady_stretch = (beats_accepted >= 300) && (beats_accepted < 450);

   nearest_palette_color_search_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Squared distance of one channel against a stored byte scaled by four
   function automatic int channel_sq(input logic [7:0] query, input logic [7:0] stored);
      int diff;
      diff = int'(query) - 4 * int'(stored);
      return diff * diff;
   endfunction

   // Walk the whole palette; strict compare keeps the lowest index on a tie
   function automatic logic [7:0] nearest_entry(input logic [7:0] red,
                                                input logic [7:0] green,
                                                input logic [7:0] blue);
      logic [21:0] sum_sq;
      logic [21:0] min_sum;
      logic [7:0]  best_index;
      min_sum    = '1;
      best_index = '0;
      for (int i = 0; i < npc_pkg::NPC_PALETTE_ENTRIES; i++) begin
         sum_sq = 22'(channel_sq(red,   palette_shadow[i][23:16])
                    + channel_sq(green, palette_shadow[i][15:8])
                    + channel_sq(blue,  palette_shadow[i][7:0]));
         if (i == 0 || sum_sq < min_sum) begin
            min_sum    = sum_sq;
            best_index = 8'(i);
         end
      end
      return best_index;
   endfunction

   // Update the shadow palette or queue the expected index for an accepted beat
   task automatic track_beat(input logic kind, input logic [31:0] data);
      if (kind == npc_pkg::KIND_LOAD) begin
         palette_shadow[data[7:0]] = {data[15:8], data[23:16], data[31:24]};
         loads_accepted++;
      end else begin
         closest_expected.push_back(nearest_entry(data[15:8], data[23:16], data[31:24]));
         queries_accepted++;
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [7:0] got,
                                input logic [7:0] want);
      mismatch_count++;
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   task automatic queue_beat(input logic kind, input logic [7:0] entry_index,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      palette_beat_type b;
      b.kind           = kind;
      b.entry_index    = entry_index;
      b.red            = red;
      b.green          = green;
      b.blue           = blue;
      b.wait_for_empty = hold_for_drain;
      hold_for_drain   = 1'b0;
      beat_queue.push_back(b);
      beats_planned++;
   endtask

   // Mix of 6-bit style levels and full-range bytes
   function automatic logic [7:0] rand_channel();
      return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 63))
                                         : 8'($urandom_range(0, 255));
   endfunction

   // Query level close to a stored byte after scaling, clamped to a byte
   function automatic logic [7:0] near_level(input logic [7:0] stored);
      int v;
      v = 4 * int'(stored) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // Request driver: present queued beats, idle at random, hold off for a drain
   always @(posedge clock) begin : drive_requests
      palette_beat_type head_beat;
      if (reset) begin
         req_tvalid <= 1'b0;
         foreach (palette_shadow[i]) palette_shadow[i] = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_beat(req_tuser[0], req_tdata);
            beats_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (beat_queue.size() != 0
                && (steady_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)
                && !(beat_queue[0].wait_for_empty && closest_expected.size() != 0)) begin
               head_beat = beat_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= head_beat.kind;
               req_tdata  <= {head_beat.blue, head_beat.green, head_beat.red,
                              head_beat.entry_index};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random backpressure, compare against the oldest expectation
   always @(posedge clock) begin : check_responses
      logic [7:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            if (closest_expected.size() == 0) begin
               flag_mismatch("response with nothing pending", rsp_tdata, 8'h00);
            end else begin
               want = closest_expected.pop_front();
               if (rsp_tdata !== want) begin
                  flag_mismatch("closest_index", rsp_tdata, want);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [23:0] recent[$];
      logic [23:0] pick;
      logic [7:0]  idx;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      int          burst;
      int          n_queries;
      bit          mid_pause_done;

      mid_pause_done = 1'b0;

      // Directed: palette all zero after reset, every entry ties
      queue_beat(npc_pkg::KIND_QUERY, 8'hA5, 8'd0,   8'd0,   8'd0);
      queue_beat(npc_pkg::KIND_QUERY, 8'h00, 8'd255, 8'd255, 8'd255);
      // Top index, brightest 6-bit level, top query wins it
      queue_beat(npc_pkg::KIND_LOAD,  8'd255, 8'd63, 8'd63, 8'd63);
      queue_beat(npc_pkg::KIND_QUERY, 8'h00, 8'd255, 8'd255, 8'd255);
      // Push entry zero far away; the next zero entry takes over
      queue_beat(npc_pkg::KIND_LOAD,  8'd0,   8'd255, 8'd255, 8'd255);
      queue_beat(npc_pkg::KIND_QUERY, 8'hFF, 8'd0,   8'd0,   8'd0);
      queue_beat(npc_pkg::KIND_LOAD,  8'd128, 8'd64,  8'd0,   8'd0);
      queue_beat(npc_pkg::KIND_QUERY, 8'h00, 8'd255, 8'd0,   8'd0);
      // Same color at two indexes: lower index wins the exact match
      queue_beat(npc_pkg::KIND_LOAD,  8'd10,  8'd10,  8'd20,  8'd30);
      queue_beat(npc_pkg::KIND_LOAD,  8'd200, 8'd10,  8'd20,  8'd30);
      queue_beat(npc_pkg::KIND_QUERY, 8'h5A, 8'd40,  8'd80,  8'd120);
      queue_beat(npc_pkg::KIND_QUERY, 8'h00, 8'd41,  8'd81,  8'd121);
      // Query halfway between two levels: equal distances
      queue_beat(npc_pkg::KIND_LOAD,  8'd3,   8'd1,   8'd0,   8'd0);
      queue_beat(npc_pkg::KIND_QUERY, 8'h00, 8'd2,   8'd0,   8'd0);
      // Largest channel differences
      queue_beat(npc_pkg::KIND_LOAD,  8'd1,   8'd0,   8'd255, 8'd0);
      queue_beat(npc_pkg::KIND_LOAD,  8'd2,   8'd0,   8'd0,   8'd255);
      queue_beat(npc_pkg::KIND_QUERY, 8'h00, 8'd0,   8'd255, 8'd0);
      queue_beat(npc_pkg::KIND_QUERY, 8'hFF, 8'd255, 8'd0,   8'd255);
      queue_beat(npc_pkg::KIND_LOAD,  8'd0,   8'd0,   8'd0,   8'd0);
      queue_beat(npc_pkg::KIND_QUERY, 8'h00, 8'd0,   8'd0,   8'd0);

      // Random: let the directed part drain first
      hold_for_drain = 1'b1;
      while (beats_planned < TOTAL_BEATS) begin
         if (!mid_pause_done && beats_planned >= MID_PAUSE_AT) begin
            hold_for_drain = 1'b1;
            mid_pause_done = 1'b1;
         end
         if ($urandom_range(0, 3) != 0) begin
            // Load a handful of entries, then look up colors mostly near them, some fully random
            recent.delete();
            burst = $urandom_range(2, 12);
            for (int k = 0; k < burst; k++) begin
               idx = 8'($urandom_range(0, 255));
               r = rand_channel();
               g = rand_channel();
               b = rand_channel();
               recent.push_back({r, g, b});
               queue_beat(npc_pkg::KIND_LOAD, idx, r, g, b);
               // Occasional duplicate color to force ties
               if ($urandom_range(0, 7) == 0) begin
                  queue_beat(npc_pkg::KIND_LOAD, 8'($urandom_range(0, 255)), r, g, b);
               end
            end
            n_queries = $urandom_range(1, 4);
            for (int k = 0; k < n_queries; k++) begin
               if ($urandom_range(0, 3) != 0) begin
                  pick = recent[$urandom_range(0, recent.size() - 1)];
                  queue_beat(npc_pkg::KIND_QUERY, 8'($urandom_range(0, 255)),
                             near_level(pick[23:16]), near_level(pick[15:8]),
                             near_level(pick[7:0]));
               end else begin
                  queue_beat(npc_pkg::KIND_QUERY, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
               end
            end
         end else begin
            // Unstructured beats with every field random
            burst = $urandom_range(1, 6);
            for (int k = 0; k < burst; k++) begin
               queue_beat(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end
         end
      end

      // Wait for the stimulus to go through and every response to come back
      while (beat_queue.size() != 0 || req_tvalid || closest_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d palette loads and %0d queries, %0d responses checked",
               loads_accepted, queries_accepted, responses_seen);
      $display("including tie breaks, exact and near matches, and full-range distances");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Reset held at the start, released once
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
